/* sv/obdrf_pkg.sv */
// obdrf_pkg: shared types and constants of the obd response filter and reassembler
// no dependencies; used by every module of the block and by obdrf_cfg_if
`default_nettype none

package obdrf_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_TYPE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_PID  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REQUEST_CLASS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ID_LOW        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_ID_HIGH       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_ENABLE = 3'd5;

    localparam logic [1:0] CLASS_SINGLE   = 2'd0;
    localparam logic [1:0] CLASS_MULTI    = 2'd1;
    localparam logic [1:0] CLASS_EXTENDED = 2'd2;

    localparam logic [8:0]  RSP_OFFSET      = 9'h040;
    localparam logic [7:0]  RSP_EXTENDED    = 8'h62;
    localparam logic [3:0]  PCI_FIRST       = 4'h1;
    localparam logic [3:0]  PCI_CONSEC      = 4'h2;
    localparam logic [10:0] FC_ID_OFFSET    = 11'd8;
    localparam logic [11:0] FIRST_PAYLOAD   = 12'd3;
    localparam logic [11:0] CONSEC_PAYLOAD  = 12'd7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;

    typedef struct packed {
        logic [7:0]  expected_type;
        logic [15:0] expected_pid;
        logic [1:0]  request_class;
        logic [10:0] id_low;
        logic [10:0] id_high;
        logic        filter_enable;
    } cfg_t;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_CLEAR,
        KIND_PASS,
        KIND_FIRST,
        KIND_CONSEC
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [10:0] fc_id;
        logic [3:0]  len;
        logic [63:0] data;
        logic [11:0] total;
    } qentry_t;

    typedef struct packed {
        logic        deliver;
        logic        send_flow_control;
        logic [10:0] flow_control_id;
        logic [3:0]  out_length;
        logic [63:0] out_data;
        logic [11:0] out_offset;
        logic [9:0]  out_frame;
        logic [11:0] out_remaining;
    } result_t;

endpackage

`default_nettype wire

/* sv/obdrf_if.sv */
// obdrf interfaces: received frame channel, result channel and register write channel
// depends on obdrf_pkg
`default_nettype none

interface obdrf_frame_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;

    modport source (output valid, mode, frame_id, frame_len, byte0, byte1, byte2, byte3,
                    byte4, byte5, byte6, byte7, input ready);
    modport sink   (input valid, mode, frame_id, frame_len, byte0, byte1, byte2, byte3,
                    byte4, byte5, byte6, byte7, output ready);
endinterface

interface obdrf_result_if;
    logic        valid;
    logic        ready;
    logic        deliver;
    logic        send_flow_control;
    logic [10:0] flow_control_id;
    logic [3:0]  out_length;
    logic [63:0] out_data;
    logic [11:0] out_offset;
    logic [9:0]  out_frame;
    logic [11:0] out_remaining;

    modport source (output valid, deliver, send_flow_control, flow_control_id, out_length,
                    out_data, out_offset, out_frame, out_remaining, input ready);
    modport sink   (input valid, deliver, send_flow_control, flow_control_id, out_length,
                    out_data, out_offset, out_frame, out_remaining, output ready);
endinterface

interface obdrf_cfg_if
    import obdrf_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/obdrf_front.sv */
// obdrf_front: configuration registers, frame acceptance and classification
// depends on obdrf_pkg and obdrf_if; feeds obdrf_queue
`default_nettype none

module obdrf_front
    import obdrf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    obdrf_cfg_if.sink    cfg,
    obdrf_frame_if.sink  rx_frame,
    input  wire logic    q_full,
    output logic         q_push,
    output qentry_t      q_entry
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic [63:0] raw;
    logic [8:0]  resp;
    logic        in_range;
    logic        single_ok;
    logic        ext_ok;
    logic        first_ok;
    logic        consec;
    kind_t       kind;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_EXPECTED_TYPE: cfg_next.expected_type = cfg.data[7:0];
                CFG_EXPECTED_PID:  cfg_next.expected_pid  = cfg.data;
                CFG_REQUEST_CLASS: cfg_next.request_class = cfg.data[1:0];
                CFG_ID_LOW:        cfg_next.id_low        = cfg.data[10:0];
                CFG_ID_HIGH:       cfg_next.id_high       = cfg.data[10:0];
                CFG_FILTER_ENABLE: cfg_next.filter_enable = cfg.data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign raw = {rx_frame.byte7, rx_frame.byte6, rx_frame.byte5, rx_frame.byte4,
                  rx_frame.byte3, rx_frame.byte2, rx_frame.byte1, rx_frame.byte0};

    // response code compared at nine bits
    assign resp      = {1'b0, cfg_reg.expected_type} + RSP_OFFSET;
    assign in_range  = (rx_frame.frame_id >= cfg_reg.id_low) &&
                       (rx_frame.frame_id <= cfg_reg.id_high);
    assign single_ok = ({1'b0, rx_frame.byte1} == resp) &&
                       ({8'h00, rx_frame.byte2} == cfg_reg.expected_pid);
    assign ext_ok    = (rx_frame.byte1 == RSP_EXTENDED) &&
                       ({rx_frame.byte2, rx_frame.byte3} == cfg_reg.expected_pid);
    assign first_ok  = (rx_frame.byte0[7:4] == PCI_FIRST) &&
                       ({1'b0, rx_frame.byte2} == resp) &&
                       ({8'h00, rx_frame.byte3} == cfg_reg.expected_pid);
    assign consec    = (rx_frame.byte0[7:4] == PCI_CONSEC);

    always_comb
    begin
        kind = KIND_NONE;
        if (rx_frame.mode)
        begin
            kind = KIND_CLEAR;
        end
        else if (!cfg_reg.filter_enable)
        begin
            kind = KIND_PASS;
        end
        else if (in_range)
        begin
            case (cfg_reg.request_class)
                CLASS_SINGLE:   kind = single_ok ? KIND_PASS : KIND_NONE;
                CLASS_EXTENDED: kind = ext_ok ? KIND_PASS : KIND_NONE;
                CLASS_MULTI:
                begin
                    if (first_ok)
                    begin
                        kind = KIND_FIRST;
                    end
                    else if (consec)
                    begin
                        kind = KIND_CONSEC;
                    end
                end
                default:        kind = KIND_NONE;
            endcase
        end
    end

    always_comb
    begin
        q_entry.kind  = kind;
        q_entry.fc_id = rx_frame.frame_id - FC_ID_OFFSET;
        q_entry.total = {rx_frame.byte0[3:0], rx_frame.byte1};
        q_entry.len   = rx_frame.frame_len;
        q_entry.data  = raw;
        case (kind)
            KIND_FIRST:
            begin
                q_entry.len  = FIRST_PAYLOAD[3:0];
                q_entry.data = {raw[63:24], raw[63:40]};
            end
            KIND_CONSEC:
            begin
                q_entry.data = {raw[63:56], raw[63:8]};
            end
            default:
            begin
                q_entry.data = raw;
            end
        endcase
    end

    assign rx_frame.ready = !q_full;
    assign q_push         = rx_frame.valid && !q_full;

endmodule

`default_nettype wire

/* sv/obdrf_queue.sv */
// obdrf_queue: two-entry queue of classified beats between front and back
// depends on obdrf_pkg
`default_nettype none

module obdrf_queue
    import obdrf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire qentry_t push_entry,
    output logic         full,
    input  wire logic    pop,
    output logic         not_empty,
    output qentry_t      head
);

    qentry_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;

    assign full      = (count_reg == QUEUE_DEPTH[QUEUE_PTR_W:0]);
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

/* sv/obdrf_back.sv */
// obdrf_back: reassembly state, result formation and output register
// depends on obdrf_pkg and obdrf_if; fed by obdrf_queue
`default_nettype none

module obdrf_back
    import obdrf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_not_empty,
    input  wire qentry_t   q_head,
    output logic           q_pop,
    obdrf_result_if.source result
);

    logic [11:0] remaining_reg;
    logic [11:0] remaining_next;
    logic [11:0] offset_reg;
    logic [11:0] offset_next;
    logic [9:0]  frame_reg;
    logic [9:0]  frame_next;
    logic        valid_reg;
    result_t     res_reg;
    result_t     res_next;

    assign q_pop = q_not_empty && (!valid_reg || result.ready);

    always_comb
    begin
        remaining_next = remaining_reg;
        offset_next    = offset_reg;
        frame_next     = frame_reg;
        res_next       = '0;
        case (q_head.kind)
            KIND_CLEAR:
            begin
                remaining_next = '0;
                offset_next    = '0;
                frame_next     = '0;
            end
            KIND_PASS:
            begin
                res_next.deliver    = 1'b1;
                res_next.out_length = q_head.len;
                res_next.out_data   = q_head.data;
            end
            KIND_FIRST:
            begin
                res_next.deliver           = 1'b1;
                res_next.send_flow_control = 1'b1;
                res_next.flow_control_id   = q_head.fc_id;
                res_next.out_length        = q_head.len;
                res_next.out_data          = q_head.data;
                remaining_next = (q_head.total > FIRST_PAYLOAD) ?
                                 q_head.total - FIRST_PAYLOAD : '0;
                offset_next    = FIRST_PAYLOAD;
                frame_next     = '0;
            end
            KIND_CONSEC:
            begin
                if (remaining_reg != '0)
                begin
                    res_next.deliver  = 1'b1;
                    res_next.out_data = q_head.data;
                    frame_next        = frame_reg + 1'b1;
                    if (remaining_reg > CONSEC_PAYLOAD)
                    begin
                        remaining_next      = remaining_reg - CONSEC_PAYLOAD;
                        offset_next         = offset_reg + CONSEC_PAYLOAD;
                        res_next.out_length = CONSEC_PAYLOAD[3:0];
                    end
                    else
                    begin
                        remaining_next      = '0;
                        offset_next         = offset_reg + remaining_reg;
                        res_next.out_length = remaining_reg[3:0];
                    end
                end
            end
            default:
            begin
                res_next.deliver = 1'b0;
            end
        endcase
        res_next.out_offset    = offset_next;
        res_next.out_frame     = frame_next;
        res_next.out_remaining = remaining_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            offset_reg    <= '0;
            frame_reg     <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                remaining_reg <= remaining_next;
                offset_reg    <= offset_next;
                frame_reg     <= frame_next;
                valid_reg     <= 1'b1;
            end
            else if (result.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid             = valid_reg;
    assign result.deliver           = res_reg.deliver;
    assign result.send_flow_control = res_reg.send_flow_control;
    assign result.flow_control_id   = res_reg.flow_control_id;
    assign result.out_length        = res_reg.out_length;
    assign result.out_data          = res_reg.out_data;
    assign result.out_offset        = res_reg.out_offset;
    assign result.out_frame         = res_reg.out_frame;
    assign result.out_remaining     = res_reg.out_remaining;

endmodule

`default_nettype wire

/* sv/obd_response_filter_reassembler_core.sv */
// obd_response_filter_reassembler_core: top level of the obd response filter and reassembler
// depends on obdrf_pkg, obdrf_if, obdrf_front, obdrf_queue, obdrf_back
//
//   channel    dir   handshake        beat contents
//   rx_frame   in    valid / ready    mode, frame_id, frame_len, byte0..byte7
//   result     out   valid / ready    deliver, flow control, length, data, offset, counts
//   cfg        in    valid / ready    register index, write data (ready always high)
//
// one beat per cycle sustained while results are taken; an accepted frame is written to
// the queue, then popped into the output register, where its result can be taken
// the front classifies combinationally into a two-entry queue, the back updates state
// and loads the output register in the same cycle
// reset clears the queue, the output register valid and all reassembly state
// a stalled result holds the back; the front keeps accepting until the queue fills
`default_nettype none

module obd_response_filter_reassembler_core
    import obdrf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    obdrf_cfg_if.sink      cfg,
    obdrf_frame_if.sink    rx_frame,
    obdrf_result_if.source result
);

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    logic    q_not_empty;
    qentry_t q_entry;
    qentry_t q_head;

    obdrf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .rx_frame (rx_frame),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    obdrf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    obdrf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .result      (result)
    );

endmodule

`default_nettype wire

/* sv/obdrf_checker.sv */
// obdrf_checker: port-level assertions on the result channel of the core
// depends on obdrf_pkg; bound to obd_response_filter_reassembler_core
`default_nettype none

module obdrf_checker
    import obdrf_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic        deliver,
    input wire logic        send_flow_control,
    input wire logic [10:0] flow_control_id,
    input wire logic [3:0]  out_length,
    input wire logic [63:0] out_data,
    input wire logic [11:0] out_offset,
    input wire logic [9:0]  out_frame
);

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    a_fc_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && send_flow_control |-> deliver)
        else $error("flow control without delivery");

    a_fc_first_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && send_flow_control |->
            out_length == FIRST_PAYLOAD[3:0] && out_offset == FIRST_PAYLOAD && out_frame == '0)
        else $error("first frame result inconsistent");

    a_no_fc_id: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !send_flow_control |-> flow_control_id == '0)
        else $error("flow control id without flow control");

    a_idle_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !deliver |-> out_length == '0 && out_data == '0)
        else $error("payload on undelivered frame");

endmodule

bind obd_response_filter_reassembler_core obdrf_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (result.valid),
    .res_ready         (result.ready),
    .deliver           (result.deliver),
    .send_flow_control (result.send_flow_control),
    .flow_control_id   (result.flow_control_id),
    .out_length        (result.out_length),
    .out_data          (result.out_data),
    .out_offset        (result.out_offset),
    .out_frame         (result.out_frame)
);

`default_nettype wire

/* tb/obd_response_filter_reassembler_core_test.sv */
`timescale 1ns / 1ps
// obd_response_filter_reassembler_core_test: drives received frames and register writes,
// predicts each result beat in a scoreboard class and compares it field by field
// depends on obdrf_pkg, obdrf_if and obd_response_filter_reassembler_core

module obd_response_filter_reassembler_core_test;
    import obdrf_pkg::*;

    localparam logic       MODE_FRAME       = 1'b0;
    localparam logic       MODE_NEW_REQUEST = 1'b1;
    localparam logic [1:0] CLASS_UNUSED     = 2'd3;
    localparam int         DRAIN_CYCLES     = 8;
    localparam int         CYCLE_LIMIT      = 200000;
    localparam int         RANDOM_PHASES    = 8;
    localparam int         BEATS_PER_PHASE  = 50;

    typedef struct packed {
        logic            mode;
        logic [10:0]     frame_id;
        logic [3:0]      frame_len;
        logic [7:0][7:0] payload;
    } rx_beat_t;

    class response_scoreboard;
        cfg_t        settings;
        logic [11:0] remaining;
        logic [11:0] offset;
        logic [9:0]  frame_count;
        result_t     pending_results[$];
        int unsigned failures;

        function new();
            settings    = '0;
            remaining   = '0;
            offset      = '0;
            frame_count = '0;
            failures    = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_EXPECTED_TYPE: settings.expected_type = value[7:0];
                CFG_EXPECTED_PID:  settings.expected_pid  = value;
                CFG_REQUEST_CLASS: settings.request_class = value[1:0];
                CFG_ID_LOW:        settings.id_low        = value[10:0];
                CFG_ID_HIGH:       settings.id_high       = value[10:0];
                CFG_FILTER_ENABLE: settings.filter_enable = value[0];
                default: ;
            endcase
        endfunction

        function void note_frame(rx_beat_t f);
            result_t         want;
            logic [8:0]      resp;
            logic [11:0]     total;
            logic [7:0][7:0] b;
            logic [7:0][7:0] shifted;
            want = '0;
            b    = f.payload;
            resp = {1'b0, settings.expected_type} + RSP_OFFSET;
            if (f.mode == MODE_NEW_REQUEST) begin
                remaining   = '0;
                offset      = '0;
                frame_count = '0;
            end else if (!settings.filter_enable) begin
                want.deliver    = 1'b1;
                want.out_length = f.frame_len;
                want.out_data   = b;
            end else if (f.frame_id >= settings.id_low && f.frame_id <= settings.id_high) begin
                case (settings.request_class)
                    CLASS_SINGLE: begin
                        if ({1'b0, b[1]} == resp && {8'h00, b[2]} == settings.expected_pid) begin
                            want.deliver    = 1'b1;
                            want.out_length = f.frame_len;
                            want.out_data   = b;
                        end
                    end
                    CLASS_EXTENDED: begin
                        if (b[1] == RSP_EXTENDED && {b[2], b[3]} == settings.expected_pid) begin
                            want.deliver    = 1'b1;
                            want.out_length = f.frame_len;
                            want.out_data   = b;
                        end
                    end
                    CLASS_MULTI: begin
                        if (b[0][7:4] == PCI_FIRST && {1'b0, b[2]} == resp
                                && {8'h00, b[3]} == settings.expected_pid) begin
                            total                  = {b[0][3:0], b[1]};
                            want.send_flow_control = 1'b1;
                            want.flow_control_id   = f.frame_id - FC_ID_OFFSET;
                            remaining   = (total > FIRST_PAYLOAD) ? total - FIRST_PAYLOAD : '0;
                            offset      = FIRST_PAYLOAD;
                            frame_count = '0;
                            shifted     = b;
                            shifted[0]  = b[5];
                            shifted[1]  = b[6];
                            shifted[2]  = b[7];
                            want.deliver    = 1'b1;
                            want.out_length = 4'(FIRST_PAYLOAD);
                            want.out_data   = shifted;
                        end else if (b[0][7:4] == PCI_CONSEC && remaining != '0) begin
                            for (int i = 0; i < 7; i++)
                                shifted[i] = b[i+1];
                            shifted[7] = b[7];
                            if (remaining > CONSEC_PAYLOAD) begin
                                remaining       = remaining - CONSEC_PAYLOAD;
                                offset          = offset + CONSEC_PAYLOAD;
                                want.out_length = 4'(CONSEC_PAYLOAD);
                            end else begin
                                want.out_length = remaining[3:0];
                                offset          = offset + remaining;
                                remaining       = '0;
                            end
                            frame_count   = frame_count + 10'd1;
                            want.deliver  = 1'b1;
                            want.out_data = shifted;
                        end
                    end
                    default: ;
                endcase
            end
            want.out_offset    = offset;
            want.out_frame     = frame_count;
            want.out_remaining = remaining;
            pending_results.push_back(want);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_results.size() == 0) begin
                $error("result beat with no expected result pending");
                failures++;
                return;
            end
            want = pending_results.pop_front();
            check_field("deliver", want.deliver, got.deliver);
            check_field("send_flow_control", want.send_flow_control, got.send_flow_control);
            check_field("flow_control_id", want.flow_control_id, got.flow_control_id);
            check_field("out_length", want.out_length, got.out_length);
            check_field("out_data", want.out_data, got.out_data);
            check_field("out_offset", want.out_offset, got.out_offset);
            check_field("out_frame", want.out_frame, got.out_frame);
            check_field("out_remaining", want.out_remaining, got.out_remaining);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    cfg_t active;
    int unsigned cycle_count;
    int unsigned stall_left;
    rx_beat_t    beats[$];

    response_scoreboard sb = new();

    obdrf_cfg_if    cfg_if();
    obdrf_frame_if  rx_if();
    obdrf_result_if res_if();

    obd_response_filter_reassembler_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_if),
        .rx_frame (rx_if),
        .result   (res_if)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("obd_response_filter_reassembler_core_test: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result('{deliver:           res_if.deliver,
                              send_flow_control: res_if.send_flow_control,
                              flow_control_id:   res_if.flow_control_id,
                              out_length:        res_if.out_length,
                              out_data:          res_if.out_data,
                              out_offset:        res_if.out_offset,
                              out_frame:         res_if.out_frame,
                              out_remaining:     res_if.out_remaining});
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // result side stalls
    initial
    begin
        res_if.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_if.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    function automatic rx_beat_t can_frame(logic [10:0] id, logic [3:0] len,
                                           logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                           logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
                                           logic [7:0] b6, logic [7:0] b7);
        rx_beat_t f;
        f.mode      = MODE_FRAME;
        f.frame_id  = id;
        f.frame_len = len;
        f.payload   = {b7, b6, b5, b4, b3, b2, b1, b0};
        return f;
    endfunction

    function automatic rx_beat_t new_request_beat();
        rx_beat_t f;
        f      = '1;
        f.mode = MODE_NEW_REQUEST;
        return f;
    endfunction

    function automatic rx_beat_t random_beat();
        rx_beat_t    f;
        logic [8:0]  resp;
        int unsigned pick;
        int unsigned byte_sel;
        int unsigned bit_sel;
        f.mode      = MODE_FRAME;
        f.frame_id  = 11'($urandom_range(0, 2047));
        f.frame_len = 4'($urandom_range(0, 15));
        f.payload   = {$urandom, $urandom};
        resp        = {1'b0, active.expected_type} + RSP_OFFSET;
        pick        = $urandom_range(0, 99);
        if (pick < 8)
            f.mode = MODE_NEW_REQUEST;
        else if (pick >= 25)
        begin
            if (active.id_low <= active.id_high)
                f.frame_id = 11'($urandom_range(active.id_low, active.id_high));
            if ($urandom_range(0, 9) < 7)
                f.frame_len = 4'd8;
            case (active.request_class)
                CLASS_SINGLE:
                begin
                    f.payload[1] = resp[7:0];
                    f.payload[2] = active.expected_pid[7:0];
                end
                CLASS_EXTENDED:
                begin
                    f.payload[1] = RSP_EXTENDED;
                    f.payload[2] = active.expected_pid[15:8];
                    f.payload[3] = active.expected_pid[7:0];
                end
                default:
                begin
                    if ($urandom_range(0, 99) < 25)
                    begin
                        f.payload[0][7:4] = PCI_FIRST;
                        if ($urandom_range(0, 4) != 0)
                        begin
                            f.payload[0][3:0] = 4'h0;
                            f.payload[1]      = 8'($urandom_range(0, 60));
                        end
                        f.payload[2] = resp[7:0];
                        f.payload[3] = active.expected_pid[7:0];
                    end
                    else
                        f.payload[0][7:4] = PCI_CONSEC;
                end
            endcase
            // occasional broken frame
            if ($urandom_range(0, 9) == 0)
            begin
                byte_sel = $urandom_range(0, 3);
                bit_sel  = $urandom_range(0, 7);
                f.payload[byte_sel][bit_sel] = ~f.payload[byte_sel][bit_sel];
            end
        end
        return f;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t        c;
        int unsigned r;
        int unsigned lo;
        int unsigned hi;
        r = $urandom_range(0, 99);
        c.request_class = (r < 50) ? CLASS_MULTI : (r < 70) ? CLASS_SINGLE :
                          (r < 88) ? CLASS_EXTENDED : CLASS_UNUSED;
        c.expected_type = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                                                        8'($urandom_range(0, 8'hBF));
        c.expected_pid  = (c.request_class == CLASS_EXTENDED || $urandom_range(0, 6) == 0) ?
                          16'($urandom) : 16'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            lo = $urandom_range(0, 2047);
            hi = lo + $urandom_range(0, 64);
            if (hi > 2047)
                hi = 2047;
        end
        else if (r < 85)
        begin
            lo = 0;
            hi = 2047;
        end
        else
        begin
            lo = $urandom_range(0, 2047);
            hi = $urandom_range(0, 2047);
        end
        c.id_low        = 11'(lo);
        c.id_high       = 11'(hi);
        c.filter_enable = ($urandom_range(0, 6) != 0);
        return c;
    endfunction

    task automatic wait_drained();
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        sb.write_reg(idx, value);
    endtask

    task automatic program_settings(cfg_t c);
        wait_drained();
        write_reg(CFG_EXPECTED_TYPE, CFG_DATA_W'(c.expected_type));
        write_reg(CFG_EXPECTED_PID,  c.expected_pid);
        write_reg(CFG_REQUEST_CLASS, CFG_DATA_W'(c.request_class));
        write_reg(CFG_ID_LOW,        CFG_DATA_W'(c.id_low));
        write_reg(CFG_ID_HIGH,       CFG_DATA_W'(c.id_high));
        write_reg(CFG_FILTER_ENABLE, CFG_DATA_W'(c.filter_enable));
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        active = c;
    endtask

    task automatic send_frame(rx_beat_t f);
        int unsigned gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            rx_if.valid <= 1'b0;
        end
        @(negedge clk);
        rx_if.valid     <= 1'b1;
        rx_if.mode      <= f.mode;
        rx_if.frame_id  <= f.frame_id;
        rx_if.frame_len <= f.frame_len;
        rx_if.byte0     <= f.payload[0];
        rx_if.byte1     <= f.payload[1];
        rx_if.byte2     <= f.payload[2];
        rx_if.byte3     <= f.payload[3];
        rx_if.byte4     <= f.payload[4];
        rx_if.byte5     <= f.payload[5];
        rx_if.byte6     <= f.payload[6];
        rx_if.byte7     <= f.payload[7];
        do
            @(posedge clk);
        while (!rx_if.ready);
        sb.note_frame(f);
    endtask

    task automatic run_frames(rx_beat_t list[$]);
        foreach (list[i])
            send_frame(list[i]);
        @(negedge clk);
        rx_if.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        steady          = 1'b0;
        active          = '0;
        cycle_count     = 0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = '0;
        cfg_if.data     = '0;
        rx_if.valid     = 1'b0;
        rx_if.mode      = MODE_FRAME;
        rx_if.frame_id  = '0;
        rx_if.frame_len = '0;
        rx_if.byte0     = '0;
        rx_if.byte1     = '0;
        rx_if.byte2     = '0;
        rx_if.byte3     = '0;
        rx_if.byte4     = '0;
        rx_if.byte5     = '0;
        rx_if.byte6     = '0;
        rx_if.byte7     = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // filter off after reset: every frame passes
        beats = '{can_frame(11'h000, 4'h0, 8'h00, 8'h00, 8'h00, 8'h00,
                            8'h00, 8'h00, 8'h00, 8'h00),
                  can_frame(11'h7FF, 4'hF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                            8'hFF, 8'hFF, 8'hFF, 8'hFF),
                  new_request_beat()};
        run_frames(beats);

        // multi frame reassembly
        program_settings('{expected_type: 8'h21, expected_pid: 16'h000D,
                           request_class: CLASS_MULTI, id_low: 11'h7E8, id_high: 11'h7EF,
                           filter_enable: 1'b1});
        beats = '{can_frame(11'h7E8, 4'h8, 8'h10, 8'h14, 8'h61, 8'h0D,
                            8'hAA, 8'hB1, 8'hB2, 8'hB3),
                  can_frame(11'h7E9, 4'h8, 8'h21, 8'h01, 8'h02, 8'h03,
                            8'h04, 8'h05, 8'h06, 8'h07),
                  can_frame(11'h7E9, 4'h8, 8'h22, 8'h11, 8'h12, 8'h13,
                            8'h14, 8'h15, 8'h16, 8'h17),
                  can_frame(11'h7E9, 4'h8, 8'h23, 8'h21, 8'h22, 8'h23,
                            8'h24, 8'h25, 8'h26, 8'h27),
                  can_frame(11'h7E9, 4'h8, 8'h24, 8'h31, 8'h32, 8'h33,
                            8'h34, 8'h35, 8'h36, 8'h37),
                  can_frame(11'h7E8, 4'h8, 8'h10, 8'h02, 8'h61, 8'h0D,
                            8'h41, 8'h42, 8'h43, 8'h44),
                  can_frame(11'h7EF, 4'h8, 8'h1F, 8'hFF, 8'h61, 8'h0D,
                            8'h51, 8'h52, 8'h53, 8'h54),
                  can_frame(11'h7EF, 4'h8, 8'h2F, 8'h61, 8'h62, 8'h63,
                            8'h64, 8'h65, 8'h66, 8'h67),
                  new_request_beat(),
                  can_frame(11'h7E8, 4'h8, 8'h21, 8'h71, 8'h72, 8'h73,
                            8'h74, 8'h75, 8'h76, 8'h77),
                  can_frame(11'h7F0, 4'h8, 8'h10, 8'h14, 8'h61, 8'h0D,
                            8'h81, 8'h82, 8'h83, 8'h84),
                  can_frame(11'h7E8, 4'h8, 8'h10, 8'h14, 8'h61, 8'h0E,
                            8'h91, 8'h92, 8'h93, 8'h94)};
        run_frames(beats);

        program_settings('{expected_type: 8'h01, expected_pid: 16'h000C,
                           request_class: CLASS_SINGLE, id_low: 11'h7E8, id_high: 11'h7EF,
                           filter_enable: 1'b1});
        beats = '{can_frame(11'h7E8, 4'h4, 8'h03, 8'h41, 8'h0C, 8'h1A,
                            8'hF8, 8'h00, 8'h00, 8'h00),
                  can_frame(11'h7E8, 4'h4, 8'h03, 8'h41, 8'h0D, 8'h1A,
                            8'hF8, 8'h00, 8'h00, 8'h00)};
        run_frames(beats);

        program_settings('{expected_type: 8'h22, expected_pid: 16'hF40D,
                           request_class: CLASS_EXTENDED, id_low: 11'h7E8, id_high: 11'h7EF,
                           filter_enable: 1'b1});
        beats = '{can_frame(11'h7EA, 4'h8, 8'h05, 8'h62, 8'hF4, 8'h0D,
                            8'h12, 8'h34, 8'h56, 8'h78),
                  can_frame(11'h7EA, 4'h8, 8'h05, 8'h62, 8'hF4, 8'h0E,
                            8'h12, 8'h34, 8'h56, 8'h78)};
        run_frames(beats);

        // highest matching type code, flow control id wraps below zero
        program_settings('{expected_type: 8'hBF, expected_pid: 16'h00FF,
                           request_class: CLASS_MULTI, id_low: 11'h000, id_high: 11'h7FF,
                           filter_enable: 1'b1});
        beats = '{can_frame(11'h003, 4'h8, 8'h10, 8'h08, 8'hFF, 8'hFF,
                            8'hC1, 8'hC2, 8'hC3, 8'hC4),
                  can_frame(11'h003, 4'h8, 8'h21, 8'hD1, 8'hD2, 8'hD3,
                            8'hD4, 8'hD5, 8'hD6, 8'hD7)};
        run_frames(beats);

        // type code that can never match, empty id range
        program_settings('{expected_type: 8'hC0, expected_pid: 16'hFFFF,
                           request_class: CLASS_SINGLE, id_low: 11'h100, id_high: 11'h0FF,
                           filter_enable: 1'b1});
        beats = '{can_frame(11'h100, 4'h8, 8'h03, 8'h00, 8'hFF, 8'hFF,
                            8'h00, 8'h00, 8'h00, 8'h00)};
        run_frames(beats);

        program_settings('{expected_type: 8'hFF, expected_pid: 16'h0000,
                           request_class: CLASS_UNUSED, id_low: 11'h000, id_high: 11'h7FF,
                           filter_enable: 1'b1});
        beats = '{can_frame(11'h7E8, 4'h8, 8'h10, 8'h14, 8'h3F, 8'h00,
                            8'h01, 8'h02, 8'h03, 8'h04)};
        run_frames(beats);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            program_settings(random_settings());
            steady = ($urandom_range(0, 4) == 0);
            beats.delete();
            for (int i = 0; i < BEATS_PER_PHASE; i++)
                beats.push_back(random_beat());
            run_frames(beats);
        end

        steady = 1'b0;
        wait_drained();
        if (sb.failures == 0)
            $display("obd_response_filter_reassembler_core_test: PASS");
        else
            $display("obd_response_filter_reassembler_core_test: FAIL");
        $finish;
    end

endmodule
